### hw/rtl/separable_box_blur_assert.svh
// Assertion macros shared by the blur block.
`ifndef SEPARABLE_BOX_BLUR_ASSERT_SVH
`define SEPARABLE_BOX_BLUR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("separable_box_blur: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("separable_box_blur: next-cycle check failed");

`endif

### hw/rtl/sbb_pkg.sv
package sbb_pkg;

  // Per-channel window sums hold up to 65 * 255, enough for a radius of 32.
  localparam int SUM_W = 15;

  // Reciprocal scaling: floor(sum / d) == (sum * RECIP[r]) >> RECIP_K for every sum in range.
  localparam int RECIP_K   = 21;
  localparam int RECIP_W   = 22;
  localparam int RAD_IDX_W = 6;
  localparam int RAD_LIMIT = 32;
  localparam int TWO_K     = 2 ** RECIP_K;

  // Job fields are sized for the largest frame and radius the block supports.
  localparam int COL_MAX_W  = 12;
  localparam int SLOT_MAX_W = 7;

  // Configuration port.
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIUS,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  localparam logic [RECIP_W-1:0] RECIP [0:RAD_LIMIT] = '{
    RECIP_W'((TWO_K + 0) / 1),   RECIP_W'((TWO_K + 2) / 3),   RECIP_W'((TWO_K + 4) / 5),
    RECIP_W'((TWO_K + 6) / 7),   RECIP_W'((TWO_K + 8) / 9),   RECIP_W'((TWO_K + 10) / 11),
    RECIP_W'((TWO_K + 12) / 13), RECIP_W'((TWO_K + 14) / 15), RECIP_W'((TWO_K + 16) / 17),
    RECIP_W'((TWO_K + 18) / 19), RECIP_W'((TWO_K + 20) / 21), RECIP_W'((TWO_K + 22) / 23),
    RECIP_W'((TWO_K + 24) / 25), RECIP_W'((TWO_K + 26) / 27), RECIP_W'((TWO_K + 28) / 29),
    RECIP_W'((TWO_K + 30) / 31), RECIP_W'((TWO_K + 32) / 33), RECIP_W'((TWO_K + 34) / 35),
    RECIP_W'((TWO_K + 36) / 37), RECIP_W'((TWO_K + 38) / 39), RECIP_W'((TWO_K + 40) / 41),
    RECIP_W'((TWO_K + 42) / 43), RECIP_W'((TWO_K + 44) / 45), RECIP_W'((TWO_K + 46) / 47),
    RECIP_W'((TWO_K + 48) / 49), RECIP_W'((TWO_K + 50) / 51), RECIP_W'((TWO_K + 52) / 53),
    RECIP_W'((TWO_K + 54) / 55), RECIP_W'((TWO_K + 56) / 57), RECIP_W'((TWO_K + 58) / 59),
    RECIP_W'((TWO_K + 60) / 61), RECIP_W'((TWO_K + 62) / 63), RECIP_W'((TWO_K + 64) / 65)
  };

  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_IDX_W-1:0] r);
    return RECIP[r];
  endfunction

  // Input word.
  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Output word.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } result_t;

  // One vertical step handed from the front end to the back end.
  typedef struct packed {
    logic                  drain;
    logic                  first_row;
    logic                  out_en;
    logic                  last;
    logic [COL_MAX_W-1:0]  col;
    logic [SLOT_MAX_W-1:0] wr_slot;
    logic [SLOT_MAX_W-1:0] old_slot;
    logic [SLOT_MAX_W-1:0] bot_slot;
    logic [2:0][7:0]       pix;
  } job_t;

  typedef struct packed {
    logic busy;
    logic drain_phase;
  } front_status_t;

endpackage

### hw/rtl/sbb_ram.sv
module sbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sbb_queue.sv
module sbb_queue import sbb_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PW = $clog2(DEPTH);

  job_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Circular buffer of jobs.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/sbb_front.sv
module sbb_front import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     restart,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]          r,
  input  logic [$clog2(MAX_WIDTH)-1:0]             w_last,
  input  logic [$clog2(MAX_HEIGHT+MAX_RADIUS)-1:0] h_last,
  input  logic                                     pixel_valid,
  output logic                                     pixel_ready,
  input  pixel_t                                   pixel,
  output logic                                     push_valid,
  input  logic                                     push_ready,
  output job_t                                     push_job,
  output front_status_t                            status
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT + MAX_RADIUS);
  localparam int RDW    = $clog2(MAX_RADIUS + 1);
  localparam int VXW    = $clog2(MAX_WIDTH + MAX_RADIUS);
  localparam int WIN    = 2 * MAX_RADIUS + 1;
  localparam int SW     = $clog2(WIN);
  localparam int PROD_W = SUM_W + RECIP_W;

  typedef enum logic [2:0] {F_IDLE, F_ADD, F_MUL, F_PUSH, F_DRAIN} state_t;

  state_t                     state;
  logic [CW-1:0]              x;
  logic [RW-1:0]              y;
  logic [SW-1:0]              cslot;
  logic [SW-1:0]              yslot;
  logic [SW-1:0]              bslot;
  logic [VXW-1:0]             vx;
  logic [SW-1:0]              vslot;
  logic [RDW-1:0]             k;
  logic                       row_end;
  logic [2:0][7:0]            pix;
  logic [23:0]                row_win [WIN];
  logic [2:0][SUM_W-1:0]      hsum;
  logic [2:0][PROD_W-1:0]     prod;

  logic [RDW:0]               twor;
  logic [RDW:0]               div;
  logic [SW:0]                div_ext;
  logic [RECIP_W-1:0]         recip_val;
  logic                       drain_phase;
  logic                       y_wrap;
  logic                       vx_past_win;
  logic                       vx_out;
  logic                       y_past_win;
  logic                       y_out;
  logic [CW-1:0]              u;
  logic [SW-1:0]              old_h;
  logic [SW-1:0]              old_v;
  logic [2:0][7:0]            old_pix;
  logic [2:0][SUM_W-1:0]      hsum_next;
  logic [2:0][7:0]            h_avg;
  logic [CW-1:0]              job_col;
  logic                       accept;

  function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] s, input logic [SW:0] d);
    logic [SW:0] se;
    se = {1'b0, s};
    if (se >= d) begin
      return SW'(se - d);
    end
    return SW'(se + (SW+1)'(WIN) - d);
  endfunction

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(WIN - 1)) ? '0 : s + 1'b1;
  endfunction

  // Window geometry and phase decode.
  assign twor        = {r, 1'b0};
  assign div         = twor + 1'b1;
  assign div_ext     = (SW+1)'(div);
  assign recip_val   = recip(RAD_IDX_W'(r));
  assign drain_phase = (y > h_last);
  assign y_wrap      = ((RW+1)'(y) == (RW+1)'(h_last) + (RW+1)'(r));
  assign vx_past_win = ({1'b0, vx} > (VXW+1)'(twor));
  assign vx_out      = ({1'b0, vx} >= (VXW+1)'(r));
  assign y_past_win  = ((RW+1)'(y) > (RW+1)'(twor));
  assign y_out       = ((RW+1)'(y) >= (RW+1)'(r));
  assign u           = CW'(vx - VXW'(r));
  assign old_h       = vx_past_win ? slot_back(vslot, div_ext) : '0;
  assign old_v       = y_past_win ? slot_back(yslot, div_ext) : '0;
  assign old_pix     = row_win[old_h];
  assign job_col     = (state == F_DRAIN) ? x : u;

  // Horizontal running sum update and the scaled quotient.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (vx == '0) begin
        hsum_next[c] = SUM_W'(div) * SUM_W'(pix[c]);
      end else begin
        hsum_next[c] = hsum[c] + SUM_W'(pix[c]) - SUM_W'(old_pix[c]);
      end
      h_avg[c] = prod[c][RECIP_K +: 8];
    end
  end

  // Job presented to the queue.
  always_comb begin
    push_job           = '0;
    push_job.drain     = (state == F_DRAIN);
    push_job.first_row = (y == '0);
    push_job.out_en    = y_out;
    push_job.last      = y_wrap && (job_col == w_last);
    push_job.col       = COL_MAX_W'(job_col);
    push_job.wr_slot   = SLOT_MAX_W'(yslot);
    push_job.old_slot  = SLOT_MAX_W'(old_v);
    push_job.bot_slot  = SLOT_MAX_W'(bslot);
    push_job.pix       = h_avg;
  end

  assign pixel_ready        = (state == F_IDLE);
  assign accept             = pixel_valid && pixel_ready;
  assign push_valid         = ((state == F_PUSH) && vx_out) || (state == F_DRAIN);
  assign status.busy        = (state != F_IDLE);
  assign status.drain_phase = drain_phase;

  // Sequencer: classify the word, run the horizontal steps, step the position.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= F_IDLE;
      x     <= '0;
      y     <= '0;
      cslot <= '0;
      yslot <= '0;
      bslot <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (!drain_phase && !pixel.func) begin
              pix     <= {pixel.blue, pixel.green, pixel.red};
              vx      <= VXW'(x);
              vslot   <= cslot;
              k       <= '0;
              row_end <= (x == w_last);
              state   <= F_ADD;
            end else if (drain_phase && pixel.func) begin
              state <= F_DRAIN;
            end
          end
        end
        F_ADD: begin
          hsum <= hsum_next;
          if (k == '0) begin
            row_win[vslot] <= pix;
          end
          state <= F_MUL;
        end
        F_MUL: begin
          for (int c = 0; c < 3; c++) begin
            prod[c] <= PROD_W'(hsum[c]) * PROD_W'(recip_val);
          end
          state <= F_PUSH;
        end
        F_PUSH, F_DRAIN: begin
          if (!push_valid || push_ready) begin
            if (state == F_PUSH && row_end && k != r) begin
              vx    <= vx + 1'b1;
              vslot <= slot_inc(vslot);
              k     <= k + 1'b1;
              state <= F_ADD;
            end else begin
              // Step to the next stream position.
              if (x == w_last) begin
                x     <= '0;
                cslot <= '0;
                if (y == h_last) begin
                  bslot <= yslot;
                end
                if (y_wrap) begin
                  y     <= '0;
                  yslot <= '0;
                end else begin
                  y     <= y + 1'b1;
                  yslot <= slot_inc(yslot);
                end
              end else begin
                x     <= x + 1'b1;
                cslot <= slot_inc(cslot);
              end
              state <= F_IDLE;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/sbb_back.sv
module sbb_back import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(MAX_RADIUS+1)-1:0] r,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  job_t                            pop_job,
  output logic                            result_valid,
  input  logic                            result_ready,
  output result_t                         result
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RDW    = $clog2(MAX_RADIUS + 1);
  localparam int WIN    = 2 * MAX_RADIUS + 1;
  localparam int SW     = $clog2(WIN);
  localparam int LAW    = SW + CW;
  localparam int PROD_W = SUM_W + RECIP_W;

  typedef enum logic [2:0] {B_IDLE, B_RD_P, B_GET_P, B_RD_OLD, B_CALC, B_MUL, B_OUT} state_t;

  state_t                 state;
  job_t                   job;
  logic [2:0][7:0]        h;
  logic [2:0][SUM_W-1:0]  cs;
  logic [2:0][PROD_W-1:0] prod;

  logic [RDW:0]           div;
  logic [RECIP_W-1:0]     recip_val;
  logic [CW-1:0]          col;
  logic [LAW-1:0]         line_raddr;
  logic [LAW-1:0]         line_waddr;
  logic                   line_we;
  logic [23:0]            line_rdata;
  logic [2:0][7:0]        old_pix;
  logic                   col_we;
  logic [3*SUM_W-1:0]     col_rdata;
  logic [2:0][SUM_W-1:0]  cs_rd;
  logic [2:0][SUM_W-1:0]  cs_next;
  logic [2:0][7:0]        v_avg;

  assign div        = {r, 1'b1};
  assign recip_val  = recip(RAD_IDX_W'(r));
  assign col        = CW'(job.col);
  assign line_raddr = (state == B_RD_P) ? {SW'(job.bot_slot), col} : {SW'(job.old_slot), col};
  assign line_waddr = {SW'(job.wr_slot), col};
  assign line_we    = (state == B_CALC) && !job.drain;
  assign col_we     = (state == B_CALC);
  assign old_pix    = line_rdata;
  assign cs_rd      = col_rdata;
  assign pop_ready  = (state == B_IDLE);

  // Blurred rows, one slot per row of the vertical window.
  sbb_ram #(
    .WIDTH (24),
    .DEPTH (WIN * (2 ** CW))
  ) u_line_store (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (h),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // Vertical running sums, one entry per column.
  sbb_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_column_sums (
    .clk   (clk),
    .we    (col_we),
    .waddr (col),
    .wdata (cs_next),
    .raddr (col),
    .rdata (col_rdata)
  );

  // Column sum update and the scaled quotient.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (job.first_row) begin
        cs_next[c] = SUM_W'(div) * SUM_W'(h[c]);
      end else begin
        cs_next[c] = cs_rd[c] + SUM_W'(h[c]) - SUM_W'(old_pix[c]);
      end
      v_avg[c] = prod[c][RECIP_K +: 8];
    end
  end

  // Sequencer for one vertical step and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            job   <= pop_job;
            h     <= pop_job.pix;
            state <= pop_job.drain ? B_RD_P : B_RD_OLD;
          end
        end
        B_RD_P:   state <= B_GET_P;
        B_GET_P: begin
          h     <= line_rdata;
          state <= B_RD_OLD;
        end
        B_RD_OLD: state <= B_CALC;
        B_CALC: begin
          cs    <= cs_next;
          state <= B_MUL;
        end
        B_MUL: begin
          for (int c = 0; c < 3; c++) begin
            prod[c] <= PROD_W'(cs[c]) * PROD_W'(recip_val);
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (!job.out_en) begin
            state <= B_IDLE;
          end else if (!result_valid || result_ready) begin
            result.out_red    <= v_avg[0];
            result.out_green  <= v_avg[1];
            result.out_blue   <= v_avg[2];
            result.frame_last <= job.last;
            result_valid      <= 1'b1;
            state             <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/separable_box_blur.sv
// Separable box blur with edge replication for an RGB frame in raster order.
// Input channel: pixel_valid / pixel_ready / pixel. A word with func = 0 is a
// pixel; once the last row is in, words with func = 1 drain the bottom rows,
// one output column per word. Words that do not fit the current phase are
// taken and dropped. Output channel: result_valid / result_ready / result;
// frame_last marks the bottom-right pixel of each frame.
// Configuration: cfg_write, cfg_index, cfg_data; radius, frame_width and
// frame_height. Any valid write restarts the frame at row 0, column 0.
// The front end takes a word only while idle and then runs a horizontal
// step (add, multiply, hand-off), repeated with the edge pixel at a row end;
// it takes no new word until the hand-off is done. A drain word goes
// straight to hand-off. The back end runs each vertical step through the
// line store and column sum read, update and reciprocal multiply, with a
// bottom-row read of the line store first for a drain word.
// A 4-entry job queue decouples the two ends. When the receiver stalls, the
// output register holds its word, the back end waits, and the queue fills
// until the front end stops taking input. Reset restores radius 1 and a
// 640 x 480 frame; the line store and column sums need no clearing.
`include "separable_box_blur_assert.svh"
module separable_box_blur import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_t                 pixel,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW          = $clog2(MAX_WIDTH);
  localparam int RW          = $clog2(MAX_HEIGHT + MAX_RADIUS);
  localparam int RDW         = $clog2(MAX_RADIUS + 1);
  localparam int QUEUE_DEPTH = 4;

  logic [3:0]            radius;
  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic                  restart;
  logic [RDW-1:0]        r_eff;
  logic [CW-1:0]         w_last;
  logic [RW-1:0]         h_last;
  logic                  push_valid;
  logic                  push_ready;
  job_t                  push_job;
  logic                  pop_valid;
  logic                  pop_ready;
  job_t                  pop_job;
  front_status_t         front_status;
  logic                  pixel_start;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= 4'd1;
      frame_width  <= CFG_DATA_W'(640);
      frame_height <= CFG_DATA_W'(480);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIUS:       radius       <= cfg_data[3:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign restart = cfg_write && (cfg_index == REG_RADIUS || cfg_index == REG_FRAME_WIDTH ||
                                 cfg_index == REG_FRAME_HEIGHT);

  // Clamp the settings into the supported range.
  always_comb begin
    r_eff = (int'(radius) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(radius);
    if (frame_width == '0) begin
      w_last = '0;
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(frame_width - 1'b1);
    end
    if (frame_height == '0) begin
      h_last = '0;
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(frame_height - 1'b1);
    end
  end

  sbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .r           (r_eff),
    .w_last      (w_last),
    .h_last      (h_last),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job),
    .status      (front_status)
  );

  sbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  sbb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .r            (r_eff),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_job      (pop_job),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A pixel word taken during the pixel phase with no register write beside it.
  assign pixel_start = pixel_valid && pixel_ready && !pixel.func &&
                       !front_status.drain_phase && !cfg_write;

  // A drain job never belongs to the top row of a frame.
  `SBB_ASSERT_SAME(a_drain_not_top, push_valid && push_job.drain, !push_job.first_row)
  // A pixel word taken during the pixel phase starts horizontal work.
  `SBB_ASSERT_NEXT(a_pixel_starts, pixel_start, front_status.busy)

endmodule
